// ===== rtl/rhht_pkg.sv =====
// rhht_pkg: shared types and constants of the robin hood hash table unit
// depends on nothing
`default_nettype none
package rhht_pkg;

   localparam int CAPACITY    = 256;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = IDX_W + 1;
   localparam int VALUE_WIDTH = 32;
   localparam int LOAD_LIMIT  = CAPACITY / 2;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [63:0] SM_GAMMA  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_LOOKUP  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_NEXT    = 3'd3,
      OP_RESTART = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RS_OK       = 2'd0,
      RS_NOTFOUND = 2'd1,
      RS_FULL     = 2'd2,
      RS_END      = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      SL_EMPTY = 2'd0,
      SL_OCC   = 2'd1,
      SL_TOMB  = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic [63:0]            key;
      logic [3:0]             len;
      logic [VALUE_WIDTH-1:0] value;
      logic [CNT_W-1:0]       pdist;
   } slot_entry_type;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_HASH = 10'b0000000010,
      S_FRD  = 10'b0000000100,
      S_FCHK = 10'b0000001000,
      S_PRD  = 10'b0000010000,
      S_PCHK = 10'b0000100000,
      S_ITER = 10'b0001000000,
      S_IOUT = 10'b0010000000,
      S_DONE = 10'b0100000000,
      S_CLR  = 10'b1000000000
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/robin_hood_hash_table_unit.sv =====
// robin_hood_hash_table_unit: open-addressed key/value table with robin hood probing
// depends on rhht_pkg
//
// channel | dir | ports                                   | beat
// req     | in  | req_valid/ready, operation,key,len,value | one operation
// rsp     | out | rsp_valid/ready, status,value,key,len,cnt| one result
// csr     | in  | csr_valid/ready, csr_data               | hash mode write
//
// hash: splitmix in 2 rounds, fnv one round per key byte, on one 32x32 multiplier
// probe: per slot, a registered slot memory read (S_FRD), then a compare (S_FCHK)
// iterate: per slot scanned, a registered read (S_ITER), then a check (S_IOUT)
// then S_DONE waits until the output register is free to take the beat; one operation at a time
// after reset a clearing pass empties one slot state per cycle, all 256 slots, not ready meanwhile
`default_nettype none
module robin_hood_hash_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [63:0] req_key_word,
   input  wire logic [3:0]  req_key_bytes,
   input  wire logic [31:0] req_value_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_value_out,
   output logic [63:0]      rsp_key_out,
   output logic [3:0]       rsp_key_bytes_out,
   output logic [8:0]       rsp_live_count,
   output logic [8:0]       rsp_tombstones,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   localparam int IW = rhht_pkg::IDX_W;
   localparam int CW = rhht_pkg::CNT_W;

   rhht_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic [3:0]  len_ff, len_in;
   logic [31:0] val_ff, val_in;
   logic [63:0] x_ff, x_in, m_ff, m_in, acc_ff, acc_in, prod_ff;
   logic [2:0]  ph_ff, ph_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] dist_ff, dist_in;
   rhht_pkg::slot_entry_type car_ff, car_in, rd_ff;
   logic [1:0]  st_rd_ff;
   logic [1:0]  res_st_ff, res_st_in;
   logic [31:0] res_val_ff, res_val_in;
   logic [63:0] res_key_ff, res_key_in;
   logic [3:0]  res_len_ff, res_len_in;
   logic [CW-1:0] live_ff, live_in, tomb_ff, tomb_in, iter_ff, iter_in;
   logic        mode_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_value_ff;
   logic [63:0] rsp_key_ff;
   logic [3:0]  rsp_len_ff;
   logic [8:0]  rsp_live_ff, rsp_tomb_ff;

   logic [1:0]  slot_st_ff [rhht_pkg::CAPACITY];
   rhht_pkg::slot_entry_type mem [rhht_pkg::CAPACITY];

   logic          st_we;
   logic [IW-1:0] st_wa;
   logic [1:0]    st_wd;
   logic          mem_we;
   logic [IW-1:0] mem_wa, rd_addr;
   rhht_pkg::slot_entry_type mem_wd;

   logic [3:0]  sat_len;
   logic [63:0] key_mask;
   logic [31:0] mul_a, mul_b;
   logic [63:0] kconst, nx, fin_src, hv, prep;
   logic [3:0]  nrounds;
   logic [1:0]  st_cur;
   logic        key_hit, out_free;
   logic [CW:0] load_sum;

   assign req_ready = (state_ff == rhht_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign sat_len = (req_key_bytes > 4'd8) ? 4'd8 : req_key_bytes;
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         key_mask[i*8 +: 8] = (4'(i) < sat_len) ? 8'hff : 8'h00;
      end
   end

   // shared multiplier for both hashes
   assign kconst = !mode_ff ? rhht_pkg::FNV_PRIME :
                   (rnd_ff == 4'd0) ? rhht_pkg::SM_MUL1 : rhht_pkg::SM_MUL2;
   assign mul_a  = (ph_ff == 3'd3) ? m_ff[63:32] : m_ff[31:0];
   assign mul_b  = (ph_ff == 3'd2) ? kconst[63:32] : kconst[31:0];
   assign nx     = acc_ff + {prod_ff[31:0], 32'd0};
   assign fin_src = (ph_ff == 3'd4) ? nx : x_ff;
   assign hv     = mode_ff ? (fin_src ^ (fin_src >> 31)) : fin_src;
   assign nrounds = mode_ff ? 4'd2 : len_ff;
   always_comb begin
      if (!mode_ff) begin
         prep = x_ff ^ {56'd0, key_ff[rnd_ff[2:0]*8 +: 8]};
      end else if (rnd_ff == 4'd0) begin
         prep = x_ff ^ (x_ff >> 30);
      end else begin
         prep = x_ff ^ (x_ff >> 27);
      end
   end

   assign st_cur   = st_rd_ff;
   assign key_hit  = (rd_ff.len == len_ff) && (rd_ff.key == key_ff);
   assign load_sum = {1'b0, live_ff} + {1'b0, tomb_ff};
   assign rd_addr  = (state_ff == rhht_pkg::S_ITER) ? iter_ff[IW-1:0] : idx_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      val_in     = val_ff;
      x_in       = x_ff;
      m_in       = m_ff;
      acc_in     = acc_ff;
      ph_in      = ph_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      dist_in    = dist_ff;
      car_in     = car_ff;
      res_st_in  = res_st_ff;
      res_val_in = res_val_ff;
      res_key_in = res_key_ff;
      res_len_in = res_len_ff;
      live_in    = live_ff;
      tomb_in    = tomb_ff;
      iter_in    = iter_ff;
      st_we      = 1'b0;
      st_wa      = idx_ff;
      st_wd      = rhht_pkg::SL_OCC;
      mem_we     = 1'b0;
      mem_wa     = idx_ff;
      mem_wd     = car_ff;
      unique case (state_ff)
         rhht_pkg::S_CLR: begin
            st_we = 1'b1;
            st_wa = iter_ff[IW-1:0];
            st_wd = rhht_pkg::SL_EMPTY;
            if (iter_ff == CW'(rhht_pkg::CAPACITY - 1)) begin
               iter_in  = '0;
               state_in = rhht_pkg::S_IDLE;
            end else begin
               iter_in = iter_ff + CW'(1);
            end
         end
         rhht_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               key_in     = req_key_word & key_mask;
               len_in     = sat_len;
               val_in     = req_value_in;
               res_st_in  = rhht_pkg::RS_OK;
               res_val_in = '0;
               res_key_in = '0;
               res_len_in = '0;
               ph_in      = 3'd0;
               rnd_in     = 4'd0;
               x_in       = mode_ff ? ((req_key_word & key_mask) + rhht_pkg::SM_GAMMA)
                                    : rhht_pkg::FNV_BASIS;
               if (req_operation <= rhht_pkg::OP_DELETE) begin
                  state_in = rhht_pkg::S_HASH;
               end else if (req_operation == rhht_pkg::OP_NEXT) begin
                  state_in = rhht_pkg::S_ITER;
               end else begin
                  if (req_operation == rhht_pkg::OP_RESTART) begin
                     iter_in = '0;
                  end
                  state_in = rhht_pkg::S_DONE;
               end
            end
         end
         rhht_pkg::S_HASH: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: m_in = prep;
               3'd2: acc_in = prod_ff;
               3'd3: acc_in = nx;
               default: ;
            endcase
            if ((ph_ff == 3'd0 && nrounds == 4'd0) ||
                (ph_ff == 3'd4 && rnd_ff + 4'd1 == nrounds)) begin
               idx_in   = hv[IW-1:0];
               dist_in  = '0;
               state_in = rhht_pkg::S_FRD;
            end else if (ph_ff == 3'd4) begin
               x_in   = nx;
               rnd_in = rnd_ff + 4'd1;
               ph_in  = 3'd0;
            end
         end
         rhht_pkg::S_FRD: begin
            state_in = rhht_pkg::S_FCHK;
         end
         rhht_pkg::S_FCHK: begin
            if (dist_ff == CW'(rhht_pkg::CAPACITY) || st_cur == rhht_pkg::SL_EMPTY ||
                (st_cur == rhht_pkg::SL_OCC && !key_hit && rd_ff.pdist < dist_ff)) begin
               // key absent
               state_in = rhht_pkg::S_DONE;
               if (op_ff != rhht_pkg::OP_INSERT) begin
                  res_st_in = rhht_pkg::RS_NOTFOUND;
               end else if (load_sum >= (CW+1)'(rhht_pkg::LOAD_LIMIT)) begin
                  res_st_in = rhht_pkg::RS_FULL;
               end else begin
                  car_in   = '{key: key_ff, len: len_ff, value: val_ff, pdist: '0};
                  idx_in   = idx_ff - dist_ff[IW-1:0];
                  state_in = rhht_pkg::S_PRD;
               end
            end else if (st_cur == rhht_pkg::SL_OCC && key_hit) begin
               state_in = rhht_pkg::S_DONE;
               if (op_ff == rhht_pkg::OP_INSERT) begin
                  mem_we = 1'b1;
                  mem_wd = '{key: rd_ff.key, len: rd_ff.len, value: val_ff,
                             pdist: rd_ff.pdist};
               end else if (op_ff == rhht_pkg::OP_LOOKUP) begin
                  res_val_in = rd_ff.value;
               end else begin
                  st_we   = 1'b1;
                  st_wd   = rhht_pkg::SL_TOMB;
                  live_in = (live_ff != '0) ? live_ff - CW'(1) : live_ff;
                  tomb_in = tomb_ff + CW'(1);
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               dist_in  = dist_ff + CW'(1);
               state_in = rhht_pkg::S_FRD;
            end
         end
         rhht_pkg::S_PRD: begin
            state_in = rhht_pkg::S_PCHK;
         end
         rhht_pkg::S_PCHK: begin
            if (st_cur != rhht_pkg::SL_OCC) begin
               mem_we  = 1'b1;
               st_we   = 1'b1;
               live_in = live_ff + CW'(1);
               if (st_cur == rhht_pkg::SL_TOMB && tomb_ff != '0) begin
                  tomb_in = tomb_ff - CW'(1);
               end
               state_in = rhht_pkg::S_DONE;
            end else begin
               if (rd_ff.pdist < car_ff.pdist) begin
                  // robin hood swap: carry the evicted entry onward
                  mem_we = 1'b1;
                  car_in = rd_ff;
               end
               car_in.pdist = ((rd_ff.pdist < car_ff.pdist) ? rd_ff.pdist : car_ff.pdist)
                              + CW'(1);
               idx_in   = idx_ff + IW'(1);
               state_in = rhht_pkg::S_PRD;
            end
         end
         rhht_pkg::S_ITER: begin
            if (iter_ff == CW'(rhht_pkg::CAPACITY)) begin
               res_st_in = rhht_pkg::RS_END;
               state_in  = rhht_pkg::S_DONE;
            end else begin
               state_in = rhht_pkg::S_IOUT;
            end
         end
         rhht_pkg::S_IOUT: begin
            iter_in = iter_ff + CW'(1);
            if (st_cur == rhht_pkg::SL_OCC) begin
               res_key_in = rd_ff.key;
               res_len_in = rd_ff.len;
               res_val_in = rd_ff.value;
               state_in   = rhht_pkg::S_DONE;
            end else begin
               state_in = rhht_pkg::S_ITER;
            end
         end
         rhht_pkg::S_DONE: begin
            if (out_free) begin
               state_in = rhht_pkg::S_IDLE;
            end
         end
         default: state_in = rhht_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhht_pkg::S_CLR;
         live_ff      <= '0;
         tomb_ff      <= '0;
         iter_ff      <= '0;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         tomb_ff  <= tomb_in;
         iter_ff  <= iter_in;
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if (state_ff == rhht_pkg::S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      val_ff     <= val_in;
      x_ff       <= x_in;
      m_ff       <= m_in;
      acc_ff     <= acc_in;
      prod_ff    <= mul_a * mul_b;
      ph_ff      <= ph_in;
      rnd_ff     <= rnd_in;
      idx_ff     <= idx_in;
      dist_ff    <= dist_in;
      car_ff     <= car_in;
      res_st_ff  <= res_st_in;
      res_val_ff <= res_val_in;
      res_key_ff <= res_key_in;
      res_len_ff <= res_len_in;
      if (state_ff == rhht_pkg::S_DONE && out_free) begin
         rsp_status_ff <= res_st_ff;
         rsp_value_ff  <= res_val_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_len_ff    <= res_len_ff;
         rsp_live_ff   <= live_ff;
         rsp_tomb_ff   <= tomb_ff;
      end
   end

   // slot state memory
   always_ff @(posedge clock) begin
      if (st_we) begin
         slot_st_ff[st_wa] <= st_wd;
      end
      st_rd_ff <= slot_st_ff[rd_addr];
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_key_out       = rsp_key_ff;
   assign rsp_key_bytes_out = rsp_len_ff;
   assign rsp_live_count    = rsp_live_ff;
   assign rsp_tombstones    = rsp_tomb_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_sum <= (CW+1)'(rhht_pkg::CAPACITY))
      else $error("slot counts exceed capacity");

   a_place_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == rhht_pkg::S_PCHK |-> load_sum < (CW+1)'(rhht_pkg::LOAD_LIMIT))
      else $error("placement above load limit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rhht_pkg::S_DONE))
      else $error("result beat without finished operation");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(live_ff)) |->
         ($past(state_ff == rhht_pkg::S_FCHK) || $past(state_ff == rhht_pkg::S_PCHK)))
      else $error("live count changed outside probe");

endmodule
`default_nettype wire
